// ----- hdl/hysteresis_heater_timed_duty_core_macros.svh -----
// Assertion macros for the hysteresis heater core.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef HYSTERESIS_HEATER_TIMED_DUTY_CORE_MACROS_SVH
`define HYSTERESIS_HEATER_TIMED_DUTY_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define HHTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HHTD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/hhtd_pkg.sv -----
// Types and constants shared by the hysteresis heater core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hhtd_pkg;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_HYST_BAND  = 2'd0,
    CFG_ON_PERIOD  = 2'd1,
    CFG_OFF_PERIOD = 2'd2,
    CFG_WARN_LIMIT = 2'd3
  } cfg_idx_e;

  localparam logic [8:0]  HystBandRst  = 9'd3;
  localparam logic [15:0] OnPeriodRst  = 16'd990;
  localparam logic [15:0] OffPeriodRst = 16'd2990;
  localparam logic [7:0]  WarnLimitRst = 8'd128;

  localparam logic [7:0] DriveFull = 8'd255;
  localparam logic [7:0] DriveOff  = 8'd0;

  localparam logic [1:0] LevelWarning = 2'd1;

  typedef struct packed {
    logic [8:0]  hysteresis_band;
    logic [15:0] on_period_ms;
    logic [15:0] off_period_ms;
    logic [7:0]  warning_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [11:0] measured_temp;
    logic signed [11:0] target_temp;
    logic [31:0]        time_now_ms;
    logic [1:0]         safety_level;
    logic               emergency_flag;
  } item_t;

  typedef struct packed {
    logic [7:0]  drive_level;
    logic        heating_now;
    logic [31:0] total_on_ms;
    logic        safety_stop;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/hhtd_cfg.sv -----
// Configuration register file of the hysteresis heater core.
// Depends on hhtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hhtd_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [hhtd_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [hhtd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output hhtd_pkg::cfg_t                      cfg_o
);
  import hhtd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_HYST_BAND:  cfg_d.hysteresis_band = cfg_wdata_i[8:0];
        CFG_ON_PERIOD:  cfg_d.on_period_ms    = cfg_wdata_i;
        CFG_OFF_PERIOD: cfg_d.off_period_ms   = cfg_wdata_i;
        CFG_WARN_LIMIT: cfg_d.warning_limit   = cfg_wdata_i[7:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hysteresis_band <= HystBandRst;
      cfg_q.on_period_ms    <= OnPeriodRst;
      cfg_q.off_period_ms   <= OffPeriodRst;
      cfg_q.warning_limit   <= WarnLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hdl/hhtd_step.sv -----
// Control update of the hysteresis heater: band decision, timed duty, warning cap,
// on-time accounting, safety stop and the controller state. Depends on hhtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hhtd_step (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire hhtd_pkg::cfg_t  cfg_i,
  input  wire hhtd_pkg::item_t item_i,
  input  wire logic            advance_i,
  output hhtd_pkg::res_t       res_o
);
  import hhtd_pkg::*;

  logic        cycle_on_q, cycle_on_d;
  logic [31:0] last_toggle_q, last_toggle_d;
  logic        was_heating_q, was_heating_d;
  logic [31:0] last_on_q, last_on_d;
  logic [31:0] total_q, total_d;

  logic               stop;
  logic               at_target;
  logic               below_band;
  logic signed [13:0] band_floor;
  logic [31:0]        elapsed;
  logic [7:0]         drive_raw;
  logic [7:0]         drive;
  logic               heating;

  always_comb begin
    stop       = item_i.emergency_flag | item_i.safety_level[1];
    at_target  = item_i.measured_temp >= item_i.target_temp;
    band_floor = 14'(item_i.target_temp) - $signed({5'b0, cfg_i.hysteresis_band});
    below_band = 14'(item_i.measured_temp) < band_floor;
    elapsed    = item_i.time_now_ms - last_toggle_q;

    cycle_on_d    = cycle_on_q;
    last_toggle_d = last_toggle_q;
    was_heating_d = was_heating_q;
    last_on_d     = last_on_q;
    total_d       = total_q;
    drive_raw     = DriveOff;

    if (at_target) begin
      cycle_on_d = 1'b0;
    end else if (below_band) begin
      drive_raw  = DriveFull;
      cycle_on_d = 1'b0;
    end else begin
      if (cycle_on_q && elapsed >= 32'(cfg_i.on_period_ms)) begin
        cycle_on_d    = 1'b0;
        last_toggle_d = item_i.time_now_ms;
      end else if (!cycle_on_q && elapsed >= 32'(cfg_i.off_period_ms)) begin
        cycle_on_d    = 1'b1;
        last_toggle_d = item_i.time_now_ms;
      end
      drive_raw = cycle_on_d ? DriveFull : DriveOff;
    end

    drive = drive_raw;
    if (item_i.safety_level == LevelWarning && drive_raw > cfg_i.warning_limit) begin
      drive = cfg_i.warning_limit;
    end
    heating = drive != DriveOff;

    if (heating && !was_heating_q) begin
      last_on_d = item_i.time_now_ms;
    end else if (!heating && was_heating_q) begin
      total_d = total_q + (item_i.time_now_ms - last_on_q);
    end
    was_heating_d = heating;

    res_o.drive_level = drive;
    res_o.heating_now = heating;
    res_o.total_on_ms = total_d;
    res_o.safety_stop = 1'b0;

    // safety stop: force off, drop the cycle, keep the accounting
    if (stop) begin
      cycle_on_d        = 1'b0;
      last_toggle_d     = last_toggle_q;
      was_heating_d     = was_heating_q;
      last_on_d         = last_on_q;
      total_d           = total_q;
      res_o.drive_level = DriveOff;
      res_o.heating_now = 1'b0;
      res_o.total_on_ms = total_q;
      res_o.safety_stop = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_on_q    <= 1'b0;
      last_toggle_q <= '0;
      was_heating_q <= 1'b0;
      last_on_q     <= '0;
      total_q       <= '0;
    end else if (advance_i) begin
      cycle_on_q    <= cycle_on_d;
      last_toggle_q <= last_toggle_d;
      was_heating_q <= was_heating_d;
      last_on_q     <= last_on_d;
      total_q       <= total_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hysteresis_heater_timed_duty_core.sv -----
// Hysteresis heater controller with timed in-band duty cycle.
// Input channel: one control update per word (temperatures, timestamp, safety status),
//   valid/ready, taken when in_valid_i and in_ready_o are both high.
// Output channel: one result word per update (drive, heating flag, total on time,
//   safety stop flag), valid/ready, taken when out_valid_o and out_ready_i are high.
// Config port: cfg_we_i writes cfg_wdata_i to the register at cfg_addr_i
//   (0 band, 1 on period, 2 off period, 3 warning limit); write only while idle.
// A taken word waits in the input register, then moves to the result register.
// Throughput: one word per cycle while the receiver takes each result; the update
//   is one combinational pass between the input register and the result register,
//   with the controller state written in the same cycle the result is loaded.
// Stall: while the result register holds an untaken word, the input register
//   still takes one more word; ready drops only when both are full.
// Reset: asynchronous, active low; clears both stages, the controller state and
//   loads the register defaults.
// Depends on hhtd_pkg, hhtd_cfg, hhtd_step and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "hysteresis_heater_timed_duty_core_macros.svh"

module hysteresis_heater_timed_duty_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [hhtd_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [hhtd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic signed [11:0]             measured_temp_i,
  input  wire logic signed [11:0]             target_temp_i,
  input  wire logic [31:0]                    time_now_ms_i,
  input  wire logic [1:0]                     safety_level_i,
  input  wire logic                           emergency_flag_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      logic [7:0]                     drive_level_o,
  output      logic                           heating_now_o,
  output      logic [31:0]                    total_on_ms_o,
  output      logic                           safety_stop_o
);
  import hhtd_pkg::*;

  cfg_t  cfg;
  item_t in_q;
  logic  in_valid_q, in_valid_d;
  res_t  res;
  res_t  out_q;
  logic  out_valid_q, out_valid_d;
  logic  advance;
  logic  in_take;

  hhtd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  hhtd_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .item_i    (in_q),
    .advance_i (advance),
    .res_o     (res)
  );

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_take     = in_valid_i && in_ready_o;
  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.measured_temp  <= measured_temp_i;
      in_q.target_temp    <= target_temp_i;
      in_q.time_now_ms    <= time_now_ms_i;
      in_q.safety_level   <= safety_level_i;
      in_q.emergency_flag <= emergency_flag_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_level_o = out_q.drive_level;
  assign heating_now_o = out_q.heating_now;
  assign total_on_ms_o = out_q.total_on_ms;
  assign safety_stop_o = out_q.safety_stop;

  `HHTD_ASSERT_IMP(a_stop_is_off, out_valid_o && safety_stop_o,
                   drive_level_o == DriveOff && !heating_now_o, "safety stop with drive on")
  `HHTD_ASSERT_IMP(a_heat_flag, out_valid_o,
                   heating_now_o == (drive_level_o != DriveOff), "heating flag mismatch")
  `HHTD_ASSERT_IMP(a_full_stall, !in_ready_o,
                   in_valid_q && out_valid_q && !out_ready_i, "ready low without full pipeline")
  `HHTD_ASSERT_NXT(a_advance_shows, advance, out_valid_o, "advanced word not shown")

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for hysteresis_heater_timed_duty_core: directed and random
// control updates, phased register settings, random idling on both channels.
// Depends on hhtd_pkg and the core; the scoreboard class below predicts every result word.

import hhtd_pkg::*;

class heater_scoreboard;
  cfg_t        cfg;
  bit          cycle_on;
  bit          was_heating;
  logic [31:0] last_toggle_ms;
  logic [31:0] last_on_ms;
  logic [31:0] on_total_ms;
  res_t        expected_q[$];
  int          err_count;

  function new();
    cfg.hysteresis_band = HystBandRst;
    cfg.on_period_ms    = OnPeriodRst;
    cfg.off_period_ms   = OffPeriodRst;
    cfg.warning_limit   = WarnLimitRst;
    cycle_on       = 1'b0;
    was_heating    = 1'b0;
    last_toggle_ms = '0;
    last_on_ms     = '0;
    on_total_ms    = '0;
    err_count      = 0;
  endfunction

  function void set_reg(cfg_idx_e idx, logic [15:0] data);
    case (idx)
      CFG_HYST_BAND:  cfg.hysteresis_band = data[8:0];
      CFG_ON_PERIOD:  cfg.on_period_ms    = data;
      CFG_OFF_PERIOD: cfg.off_period_ms   = data;
      CFG_WARN_LIMIT: cfg.warning_limit   = data[7:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // advance the controller state by one accepted word and queue its result
  function void note_update(item_t it);
    int          temp;
    int          target;
    logic [31:0] elapsed;
    logic [7:0]  drive;
    bit          heating;
    res_t        r;
    temp   = int'($signed(it.measured_temp));
    target = int'($signed(it.target_temp));
    if (it.emergency_flag || it.safety_level >= 2'd2) begin
      cycle_on      = 1'b0;
      r.drive_level = DriveOff;
      r.heating_now = 1'b0;
      r.total_on_ms = on_total_ms;
      r.safety_stop = 1'b1;
      expected_q.push_back(r);
      return;
    end
    if (temp >= target) begin
      drive    = DriveOff;
      cycle_on = 1'b0;
    end else if (temp < target - int'(cfg.hysteresis_band)) begin
      drive    = DriveFull;
      cycle_on = 1'b0;
    end else begin
      elapsed = it.time_now_ms - last_toggle_ms;
      if (cycle_on && elapsed >= 32'(cfg.on_period_ms)) begin
        cycle_on       = 1'b0;
        last_toggle_ms = it.time_now_ms;
      end else if (!cycle_on && elapsed >= 32'(cfg.off_period_ms)) begin
        cycle_on       = 1'b1;
        last_toggle_ms = it.time_now_ms;
      end
      drive = cycle_on ? DriveFull : DriveOff;
    end
    if (it.safety_level == LevelWarning && drive > cfg.warning_limit) begin
      drive = cfg.warning_limit;
    end
    heating = (drive != DriveOff);
    if (heating && !was_heating) begin
      last_on_ms = it.time_now_ms;
    end else if (!heating && was_heating) begin
      on_total_ms = on_total_ms + (it.time_now_ms - last_on_ms);
    end
    was_heating   = heating;
    r.drive_level = drive;
    r.heating_now = heating;
    r.total_on_ms = on_total_ms;
    r.safety_stop = 1'b0;
    expected_q.push_back(r);
  endfunction

  task report(string msg);
    err_count++;
    if (err_count <= 60) begin
      $display("mismatch: %s", msg);
    end
  endtask

  task check_result(res_t got);
    res_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected word, drive %0d total %0d", got.drive_level,
                       got.total_on_ms));
      return;
    end
    want = expected_q.pop_front();
    if (got.drive_level !== want.drive_level) begin
      report($sformatf("drive_level %0d, want %0d", got.drive_level, want.drive_level));
    end
    if (got.heating_now !== want.heating_now) begin
      report($sformatf("heating_now %0b, want %0b", got.heating_now, want.heating_now));
    end
    if (got.total_on_ms !== want.total_on_ms) begin
      report($sformatf("total_on_ms %0d, want %0d", got.total_on_ms, want.total_on_ms));
    end
    if (got.safety_stop !== want.safety_stop) begin
      report($sformatf("safety_stop %0b, want %0b", got.safety_stop, want.safety_stop));
    end
  endtask

  task final_check();
    while (expected_q.size() != 0) begin
      void'(expected_q.pop_front());
      report("expected word never arrived");
    end
  endtask
endclass

module testbench;
  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 100;
  localparam int NumPhases  = 8;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [11:0] measured_temp_i;
  logic signed [11:0] target_temp_i;
  logic [31:0]        time_now_ms_i;
  logic [1:0]         safety_level_i;
  logic               emergency_flag_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [7:0]         drive_level_o;
  logic               heating_now_o;
  logic [31:0]        total_on_ms_o;
  logic               safety_stop_o;

  heater_scoreboard sb;
  bit               bursty;
  logic [31:0]      now_ms;
  int               cycles;
  res_t             seen;

  hysteresis_heater_timed_duty_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .measured_temp_i  (measured_temp_i),
    .target_temp_i    (target_temp_i),
    .time_now_ms_i    (time_now_ms_i),
    .safety_level_i   (safety_level_i),
    .emergency_flag_i (emergency_flag_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_level_o    (drive_level_o),
    .heating_now_o    (heating_now_o),
    .total_on_ms_o    (total_on_ms_o),
    .safety_stop_o    (safety_stop_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.drive_level = drive_level_o;
      seen.heating_now = heating_now_o;
      seen.total_on_ms = total_on_ms_o;
      seen.safety_stop = safety_stop_o;
      sb.check_result(seen);
    end
  end

  // receiver stalls in random bursts
  initial begin : result_sink
    int hold;
    hold        = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        if (hold == 0) out_ready_i = 1'b1;
      end else if (bursty && $urandom_range(0, 5) == 0) begin
        out_ready_i = 1'b0;
        hold        = $urandom_range(1, 8);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  function automatic item_t make_update(int temp, int target, logic [31:0] t, int lvl,
                                        bit emerg);
    item_t it;
    it.measured_temp  = temp[11:0];
    it.target_temp    = target[11:0];
    it.time_now_ms    = t;
    it.safety_level   = lvl[1:0];
    it.emergency_flag = emerg;
    return it;
  endfunction

  function automatic int clamp12(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  function automatic item_t random_update();
    int  target;
    int  temp;
    int  band;
    int  span;
    int  lvl;
    int  kind;
    bit  emerg;
    if ($urandom_range(0, 9) == 0) begin
      now_ms = $urandom();
      return make_update($urandom_range(0, 4095), $urandom_range(0, 4095), now_ms,
                         $urandom_range(0, 3), $urandom_range(0, 1));
    end
    band = int'(sb.cfg.hysteresis_band);
    span = int'(sb.cfg.on_period_ms) + int'(sb.cfg.off_period_ms);
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      now_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    end else begin
      now_ms = now_ms + $urandom_range(0, span / 2 + span / 8 + 2);
    end
    target = $urandom_range(0, 4000) - 2000;
    kind   = $urandom_range(0, 19);
    if (kind < 12) begin
      temp = target - $urandom_range(0, band);
    end else if (kind < 15) begin
      temp = target + $urandom_range(0, 40);
    end else if (kind < 18) begin
      temp = target - band - $urandom_range(1, 300);
    end else begin
      temp = $urandom_range(0, 4000) - 2000;
    end
    kind  = $urandom_range(0, 99);
    lvl   = (kind < 80) ? 0 : (kind < 94) ? 1 : $urandom_range(2, 3);
    emerg = ($urandom_range(0, 39) == 0);
    return make_update(clamp12(temp), target, now_ms, lvl, emerg);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_update(item_t it);
    if (bursty && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    measured_temp_i  = it.measured_temp;
    target_temp_i    = it.target_temp;
    time_now_ms_i    = it.time_now_ms;
    safety_level_i   = it.safety_level;
    emergency_flag_i = it.emergency_flag;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_update(it);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic apply_setting(int band, int on_ms, int off_ms, int warn);
    write_reg(CFG_HYST_BAND, band[15:0]);
    write_reg(CFG_ON_PERIOD, on_ms[15:0]);
    write_reg(CFG_OFF_PERIOD, off_ms[15:0]);
    write_reg(CFG_WARN_LIMIT, warn[15:0]);
  endtask

  initial begin : stimulus
    int p;
    int n;
    sb               = new();
    bursty           = 1'b1;
    now_ms           = '0;
    cycles           = 0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_addr_i       = CFG_HYST_BAND;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    measured_temp_i  = '0;
    target_temp_i    = '0;
    time_now_ms_i    = '0;
    safety_level_i   = '0;
    emergency_flag_i = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset defaults: band 3, periods 990 / 2990, warning cap 128
    send_update(make_update(200, 200, 32'd0, 0, 0));
    send_update(make_update(2047, -2048, 32'd10, 0, 0));
    send_update(make_update(-2048, 2047, 32'd100, 0, 0));
    send_update(make_update(199, 200, 32'd1000, 0, 0));
    send_update(make_update(197, 200, 32'd3000, 0, 0));
    send_update(make_update(198, 200, 32'd3500, 1, 0));
    send_update(make_update(198, 200, 32'd4000, 0, 0));
    send_update(make_update(0, 500, 32'd4100, 1, 0));
    send_update(make_update(0, 500, 32'd4200, 2, 0));
    send_update(make_update(0, 500, 32'd4300, 3, 0));
    send_update(make_update(0, 500, 32'd4400, 0, 1));
    send_update(make_update(0, 500, 32'd4500, 3, 1));
    send_update(make_update(199, 200, 32'hFFFF_FFF0, 0, 0));
    send_update(make_update(199, 200, 32'h0000_0400, 0, 0));
    send_update(make_update(-2048, -2048, 32'h0000_0500, 0, 0));
    send_update(make_update(-2048, 2047, 32'hFFFF_FFFF, 1, 0));
    send_update(make_update(2047, 2047, 32'h8000_0000, 0, 0));
    wait_drained();

    for (p = 0; p < NumPhases; p++) begin
      case (p)
        0: apply_setting(10, 50, 120, 200);
        1: apply_setting(0, 0, 0, 0);
        2: apply_setting(511, 65535, 65535, 255);
        3: apply_setting(1, 1, 1, 1);
        4: apply_setting(500, 0, 65535, 128);
        default: apply_setting($urandom_range(0, 511),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 300),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 300),
                               $urandom_range(0, 255));
      endcase
      bursty = (p != 2) && (p != NumPhases - 1);
      for (n = 0; n < PhaseItems; n++) begin
        if (p == 0 && n == PhaseItems / 2) wait_drained();
        send_update(random_update());
      end
      wait_drained();
    end

    repeat (8) @(negedge clk_i);
    sb.final_check();
    if (sb.err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
